// ===== rtl/core/hspf_pkg.sv =====
// ----------------------------------------------------------------------------
// hspf_pkg: shared constants for the hash size prime finder
// Widths of the datapath, the fixed-point scale factors and the item fields.
// ----------------------------------------------------------------------------
package hspf_pkg;

    // Width of the request bits that take part in the sizing
    localparam int SIZE_BITS = 30;

    // Item field widths
    localparam int REQ_W   = 30;
    localparam int PRIME_W = 31;

    // Working width of the candidate and the power of two
    localparam int NW  = SIZE_BITS + 2;
    // Scale factors and the shared divider's divisor width
    localparam int KW  = 24;
    // Product width of a scaling multiply
    localparam int PRW = NW + KW;
    // Trial divisor width and width of its square
    localparam int DW  = NW / 2 + 2;
    localparam int SW  = NW + 1;
    // Divider iteration counter width
    localparam int CW  = $clog2(PRW + 1);

    localparam logic [NW-1:0] SIZE_MASK = NW'((64'd1 << SIZE_BITS) - 64'd1);

    // Scale factors, value times ten million
    localparam logic [KW-1:0] SCALE_DEN   = KW'(10000000);
    localparam logic [KW-1:0] K_NEAR_LOW  = KW'(10412321);
    localparam logic [KW-1:0] K_NEAR_HIGH = KW'(11131347);
    localparam logic [KW-1:0] K_FINAL     = KW'(10132677);

    localparam logic [NW-1:0] SIZE_BIAS  = NW'(100);
    localparam logic [NW:0]   NEAR_MARGIN = (NW+1)'(20);
    localparam logic [NW-1:0] NEAR_BUMP  = NW'(30);

endpackage

// ===== rtl/core/hspf_req_if.sv =====
// ----------------------------------------------------------------------------
// hspf_req_if: request channel
// Valid/ready channel that carries one requested table size per item.
// ----------------------------------------------------------------------------
interface hspf_req_if;
    logic                       valid;
    logic                       ready;
    logic [hspf_pkg::REQ_W-1:0] requested_size;

    modport source (output valid, output requested_size, input ready);
    modport sink   (input valid, input requested_size, output ready);
endinterface

// ===== rtl/core/hspf_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hspf_rsp_if: result channel
// Valid/ready channel that carries one prime table size per item.
// ----------------------------------------------------------------------------
interface hspf_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [hspf_pkg::PRIME_W-1:0] prime_size;

    modport source (output valid, output prime_size, input ready);
    modport sink   (input valid, input prime_size, output ready);
endinterface

// ===== rtl/core/hash_size_prime_finder_unit.sv =====
// Flow: a request is taken only in idle, after the previous item has been
//   handed to the result register; a single restoring divider (one quotient
//   bit a cycle) serves both the fixed-point scalings and the trial divisions.
// Reset: synchronous, active low; clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
// hash_size_prime_finder_unit: prime table size finder
// Raises and scales a requested size away from powers of two, then searches
// upward for the first prime by trial division on a shared divider.
// ----------------------------------------------------------------------------
module hash_size_prime_finder_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    hspf_req_if.sink         i_req,
    hspf_rsp_if.source       o_rsp
);

    localparam int NW  = hspf_pkg::NW;
    localparam int KW  = hspf_pkg::KW;
    localparam int PRW = hspf_pkg::PRW;
    localparam int DW  = hspf_pkg::DW;
    localparam int SW  = hspf_pkg::SW;
    localparam int CW  = hspf_pkg::CW;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_POW   = 10'b00_0000_0010,
        S_CMP1  = 10'b00_0000_0100,
        S_MUL   = 10'b00_0000_1000,
        S_DIV   = 10'b00_0001_0000,
        S_CMP2  = 10'b00_0010_0000,
        S_ADJ   = 10'b00_0100_0000,
        S_TRIAL = 10'b00_1000_0000,
        S_DONE  = 10'b01_0000_0000,
        S_START = 10'b10_0000_0000
    } t_state;

    typedef enum logic [1:0] {
        OP_SCALE_LOW   = 2'd0,
        OP_SCALE_HIGH  = 2'd1,
        OP_SCALE_FINAL = 2'd2,
        OP_MOD         = 2'd3
    } t_op;

    t_state r_state, n_state;
    t_op    r_op, n_op;
    logic   r_out_valid, n_out_valid;

    logic [NW-1:0]            r_n, n_n;
    logic [NW-1:0]            r_p, n_p;
    logic [DW-1:0]            r_d, n_d;
    logic [SW-1:0]            r_sq, n_sq;
    logic [PRW-1:0]           r_dvd, n_dvd;
    logic [KW-1:0]            r_rem, n_rem;
    logic [KW-1:0]            r_dvs, n_dvs;
    logic [CW-1:0]            r_cnt, n_cnt;
    logic [hspf_pkg::PRIME_W-1:0] r_out, n_out;

    // Shared divider step
    logic [KW:0]    rem_sh;
    logic           div_ge;
    logic [KW-1:0]  step_rem;
    logic [PRW-1:0] step_dvd;

    logic [NW+6:0]  n_x100;
    logic [NW+6:0]  p_x105;
    logic [NW+6:0]  p_x95;
    logic [KW-1:0]  k_sel;

    assign rem_sh   = {r_rem, r_dvd[PRW-1]};
    assign div_ge   = rem_sh >= {1'b0, r_dvs};
    assign step_rem = div_ge ? KW'(rem_sh - {1'b0, r_dvs}) : rem_sh[KW-1:0];
    assign step_dvd = {r_dvd[PRW-2:0], div_ge};

    assign n_x100 = (NW+7)'(r_n) * (NW+7)'(100);
    assign p_x105 = (NW+7)'(r_p) * (NW+7)'(105);
    assign p_x95  = (NW+7)'(r_p) * (NW+7)'(95);

    always_comb begin
        case (r_op)
            OP_SCALE_LOW:   k_sel = hspf_pkg::K_NEAR_LOW;
            OP_SCALE_HIGH:  k_sel = hspf_pkg::K_NEAR_HIGH;
            OP_SCALE_FINAL: k_sel = hspf_pkg::K_FINAL;
            default:        k_sel = hspf_pkg::K_FINAL;
        endcase
    end

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.prime_size = r_out;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_out_valid = r_out_valid;
        n_n         = r_n;
        n_p         = r_p;
        n_d         = r_d;
        n_sq        = r_sq;
        n_dvd       = r_dvd;
        n_rem       = r_rem;
        n_dvs       = r_dvs;
        n_cnt       = r_cnt;
        n_out       = r_out;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_n     = (NW'(i_req.requested_size) & hspf_pkg::SIZE_MASK)
                              + hspf_pkg::SIZE_BIAS;
                    n_p     = NW'(1);
                    n_state = S_POW;
                end
            end
            S_POW: begin
                // Advance p until 2p reaches n
                if ({r_p, 1'b0} < {1'b0, r_n}) begin
                    n_p = {r_p[NW-2:0], 1'b0};
                end else begin
                    n_state = S_CMP1;
                end
            end
            S_CMP1: begin
                n_p = {r_p[NW-2:0], 1'b0};
                if (n_x100 < p_x105) begin
                    n_op    = OP_SCALE_LOW;
                    n_state = S_MUL;
                end else begin
                    n_state = S_CMP2;
                end
            end
            S_CMP2: begin
                if (n_x100 > p_x95) begin
                    n_op    = OP_SCALE_HIGH;
                    n_state = S_MUL;
                end else begin
                    n_state = S_ADJ;
                end
            end
            S_ADJ: begin
                if ((NW+1)'(r_n) + hspf_pkg::NEAR_MARGIN > (NW+1)'(r_p)) begin
                    n_n = r_n + hspf_pkg::NEAR_BUMP;
                end
                n_op    = OP_SCALE_FINAL;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_dvd   = PRW'(r_n) * PRW'(k_sel);
                n_rem   = '0;
                n_dvs   = hspf_pkg::SCALE_DEN;
                n_cnt   = CW'(PRW);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_dvd = step_dvd;
                n_rem = step_rem;
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    case (r_op)
                        OP_SCALE_LOW: begin
                            n_n     = step_dvd[NW-1:0];
                            n_state = S_CMP2;
                        end
                        OP_SCALE_HIGH: begin
                            n_n     = step_dvd[NW-1:0];
                            n_state = S_ADJ;
                        end
                        OP_SCALE_FINAL: begin
                            n_n     = step_dvd[NW-1:0];
                            n_state = S_START;
                        end
                        default: begin
                            // Divisor hit: drop this candidate and restart at two
                            if (step_rem == '0) begin
                                n_n     = r_n + NW'(1);
                                n_state = S_START;
                            end else begin
                                n_d     = r_d + DW'(1);
                                n_sq    = r_sq + SW'({r_d, 1'b0}) + SW'(1);
                                n_state = S_TRIAL;
                            end
                        end
                    endcase
                end
            end
            S_START: begin
                n_d     = DW'(2);
                n_sq    = SW'(4);
                n_state = S_TRIAL;
            end
            S_TRIAL: begin
                if (r_sq > SW'(r_n)) begin
                    n_state = S_DONE;
                end else begin
                    n_dvd   = {r_n, {(PRW-NW){1'b0}}};
                    n_rem   = '0;
                    n_dvs   = KW'(r_d);
                    n_cnt   = CW'(NW);
                    n_op    = OP_MOD;
                    n_state = S_DIV;
                end
            end
            S_DONE: begin
                // Hold until the result register is free
                if (!r_out_valid || o_rsp.ready) begin
                    n_out       = hspf_pkg::PRIME_W'(r_n);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_op        <= OP_SCALE_LOW;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_op        <= n_op;
            r_cnt       <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n   <= n_n;
        r_p   <= n_p;
        r_d   <= n_d;
        r_sq  <= n_sq;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_out <= n_out;
    end

endmodule
